// ----- sv/byc_pkg.sv -----
// ----------------------------------------------------------------------------
// byc_pkg
// Shared types and constants of the BGRA to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package byc_pkg;

   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_WIDTH   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   localparam logic [CSR_DATA_W-1:0] LINE_WIDTH_RESET   = 13'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // BT.601 studio-range coefficients
   localparam logic [7:0] Y_COEF_R  = 8'd66;
   localparam logic [7:0] Y_COEF_G  = 8'd129;
   localparam logic [7:0] Y_COEF_B  = 8'd25;
   localparam logic [7:0] ROUND_ADD = 8'd128;
   localparam logic [7:0] Y_OFFSET  = 8'd16;
   localparam logic [7:0] CB_COEF_R = 8'd38;   // subtracted
   localparam logic [7:0] CB_COEF_G = 8'd74;   // subtracted
   localparam logic [7:0] CB_COEF_B = 8'd112;
   localparam logic [7:0] CR_COEF_R = 8'd112;
   localparam logic [7:0] CR_COEF_G = 8'd94;   // subtracted
   localparam logic [7:0] CR_COEF_B = 8'd18;   // subtracted
   // rounding plus the 128 chroma offset, pre-shift: 128 + (128 << 8)
   localparam logic [16:0] C_BIAS   = 17'd32896;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] luma;
      logic       luma_valid;
      logic       chroma_valid;
      logic [7:0] cb;
      logic [7:0] cr;
      logic       frame_end;
   } rsp_payload_type;

   // channel sums of a horizontal pixel pair
   typedef struct packed {
      logic [8:0] red;
      logic [8:0] green;
      logic [8:0] blue;
   } pair_sum_type;

endpackage

`default_nettype wire

// ----- sv/byc_line_buf.sv -----
// ----------------------------------------------------------------------------
// byc_line_buf
// Line buffer of even-row pair sums: one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module byc_line_buf #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire byc_pkg::pair_sum_type wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output byc_pkg::pair_sum_type      rd_data
);
   import byc_pkg::*;

   pair_sum_type mem_ff [DEPTH];
   pair_sum_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/bgra_to_yuv420_converter.sv -----
// ----------------------------------------------------------------------------
// bgra_to_yuv420_converter
// Raster-order BGR pixels in, BT.601 studio-range luma per pixel and one
// Cb/Cr pair per 2x2 block out, with a line buffer of even-row pair sums.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request passes through the stage 1, stage 2 and
//   output registers before its response is valid.
// Throughput: one pixel per clock unless the output stalls; the line buffer
//   takes one write and one read per cycle; a pixel touches it at most once.
// Reset (synchronous, active high): counters, pair sums and pipeline valids
//   clear, size registers return to 640 x 480. The line buffer is not
//   cleared; every entry is written by an even row before it is read.
`default_nettype none

module bgra_to_yuv420_converter #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // pixel requests
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire byc_pkg::req_payload_type             req_data,
   // results
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output byc_pkg::rsp_payload_type                  rsp_data,
   // register writes
   input  wire logic                                 csr_wr_en,
   input  wire logic [byc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [byc_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import byc_pkg::*;

   localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W      = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int LEN_W      = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   // ---------------------------------------------------------------------
   // Size registers
   // ---------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] line_width_ff, line_width_in;
   logic [CSR_DATA_W-1:0] frame_height_ff, frame_height_in;

   always_comb begin
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_LINE_WIDTH:   line_width_in   = csr_wr_data;
            REG_FRAME_HEIGHT: frame_height_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LINE_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Clamp sizes to [2, MAX]; the extra top bit lets MAX reach 8192.
   logic [CSR_DATA_W:0] width_ext, height_ext;
   logic [LEN_W-1:0]    line_len, last_col, even_len;
   logic [HGT_W-1:0]    frame_hgt, last_row, even_hgt;

   assign width_ext  = {1'b0, line_width_ff};
   assign height_ext = {1'b0, frame_height_ff};

   always_comb begin
      if (width_ext < (CSR_DATA_W + 1)'(2)) begin
         line_len = LEN_W'(2);
      end else if (width_ext > (CSR_DATA_W + 1)'(MAX_WIDTH)) begin
         line_len = LEN_W'(MAX_WIDTH);
      end else begin
         line_len = LEN_W'(width_ext);
      end
      if (height_ext < (CSR_DATA_W + 1)'(2)) begin
         frame_hgt = HGT_W'(2);
      end else if (height_ext > (CSR_DATA_W + 1)'(MAX_HEIGHT)) begin
         frame_hgt = HGT_W'(MAX_HEIGHT);
      end else begin
         frame_hgt = HGT_W'(height_ext);
      end
   end

   assign last_col = line_len - LEN_W'(1);
   assign even_len = line_len & ~LEN_W'(1);
   assign last_row = frame_hgt - HGT_W'(1);
   assign even_hgt = frame_hgt & ~HGT_W'(1);

   // ---------------------------------------------------------------------
   // Pipeline control: all stages advance together while the output
   // register is empty or being taken.
   // ---------------------------------------------------------------------
   logic advance, accept;
   logic s1_valid_ff, s2_valid_ff, out_valid_ff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign accept    = req_valid && advance;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: raster position, luma, pair sums, line buffer access
   // ---------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   pair_sum_type     pair_ff, pair_in;

   logic line_last, frame_last, y_valid, c_valid, col_odd, row_odd;
   logic [15:0]  luma_acc;
   logic [7:0]   luma_now;
   pair_sum_type pixel_sum;

   assign line_last  = LEN_W'(col_ff) >= last_col;
   assign frame_last = line_last && (HGT_W'(row_ff) >= last_row);
   assign y_valid    = (LEN_W'(col_ff) < even_len) && (HGT_W'(row_ff) < even_hgt);
   assign col_odd    = col_ff[0];
   assign row_odd    = row_ff[0];
   assign c_valid    = y_valid && col_odd && row_odd;

   assign luma_acc = 16'(Y_COEF_R * req_data.red) + 16'(Y_COEF_G * req_data.green)
                   + 16'(Y_COEF_B * req_data.blue) + 16'(ROUND_ADD);
   assign luma_now = y_valid ? (luma_acc[15:8] + Y_OFFSET) : 8'd0;

   // the even-column pixel's channels plus this pixel's
   assign pixel_sum.red   = pair_ff.red   + {1'b0, req_data.red};
   assign pixel_sum.green = pair_ff.green + {1'b0, req_data.green};
   assign pixel_sum.blue  = pair_ff.blue  + {1'b0, req_data.blue};

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pair_in = pair_ff;
      if (accept) begin
         if (line_last) begin
            col_in = '0;
            row_in = frame_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
         if (y_valid && !col_odd) begin
            pair_in = {1'b0, req_data.red, 1'b0, req_data.green, 1'b0, req_data.blue};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         pair_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         pair_ff <= pair_in;
      end
   end

   // Even rows write the block's top pair; odd rows read it back. The same
   // entry is never written and read at one edge (rows differ), and the
   // write always lands at least one request ahead of the matching read.
   logic [LINE_AW-1:0] slot;
   logic               lb_wr_en, lb_rd_en;
   pair_sum_type       lb_rd_data;

   assign slot     = LINE_AW'(col_ff >> 1);
   assign lb_wr_en = accept && y_valid && col_odd && !row_odd;
   assign lb_rd_en = accept && c_valid;

   byc_line_buf #(
      .DEPTH  (LINE_DEPTH),
      .ADDR_W (LINE_AW)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (lb_wr_en),
      .wr_addr (slot),
      .wr_data (pixel_sum),
      .rd_en   (lb_rd_en),
      .rd_addr (slot),
      .rd_data (lb_rd_data)
   );

   // ---------------------------------------------------------------------
   // Stage 1: hold luma, flags and bottom-pair sums beside the read word
   // ---------------------------------------------------------------------
   logic [7:0]   s1_luma_ff;
   logic         s1_y_valid_ff, s1_c_valid_ff, s1_frame_end_ff;
   pair_sum_type s1_sum_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_luma_ff      <= luma_now;
         s1_y_valid_ff   <= y_valid;
         s1_c_valid_ff   <= c_valid;
         s1_frame_end_ff <= frame_last;
         s1_sum_ff       <= pixel_sum;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: four-pixel block sums, divided by four with truncation
   // ---------------------------------------------------------------------
   logic [9:0] blk_r, blk_g, blk_b;
   logic [7:0] s2_avg_r_ff, s2_avg_g_ff, s2_avg_b_ff;
   logic [7:0] s2_luma_ff;
   logic       s2_y_valid_ff, s2_c_valid_ff, s2_frame_end_ff;

   assign blk_r = {1'b0, s1_sum_ff.red}   + {1'b0, lb_rd_data.red};
   assign blk_g = {1'b0, s1_sum_ff.green} + {1'b0, lb_rd_data.green};
   assign blk_b = {1'b0, s1_sum_ff.blue}  + {1'b0, lb_rd_data.blue};

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_avg_r_ff     <= blk_r[9:2];
         s2_avg_g_ff     <= blk_g[9:2];
         s2_avg_b_ff     <= blk_b[9:2];
         s2_luma_ff      <= s1_luma_ff;
         s2_y_valid_ff   <= s1_y_valid_ff;
         s2_c_valid_ff   <= s1_c_valid_ff;
         s2_frame_end_ff <= s1_frame_end_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: chroma. The biased sums stay within 0..65535, so modular
   // 17-bit arithmetic gives the floor shift exactly.
   // ---------------------------------------------------------------------
   logic [16:0]     cb_acc, cr_acc;
   rsp_payload_type out_ff;

   assign cb_acc = C_BIAS + 17'(CB_COEF_B * s2_avg_b_ff)
                 - 17'(CB_COEF_R * s2_avg_r_ff) - 17'(CB_COEF_G * s2_avg_g_ff);
   assign cr_acc = C_BIAS + 17'(CR_COEF_R * s2_avg_r_ff)
                 - 17'(CR_COEF_G * s2_avg_g_ff) - 17'(CR_COEF_B * s2_avg_b_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.luma         <= s2_luma_ff;
         out_ff.luma_valid   <= s2_y_valid_ff;
         out_ff.chroma_valid <= s2_c_valid_ff;
         out_ff.cb           <= s2_c_valid_ff ? cb_acc[15:8] : 8'd0;
         out_ff.cr           <= s2_c_valid_ff ? cr_acc[15:8] : 8'd0;
         out_ff.frame_end    <= s2_frame_end_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// ----- sv/byc_checker.sv -----
// ----------------------------------------------------------------------------
// byc_checker
// Port-level checks of the converter's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module byc_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire byc_pkg::rsp_payload_type  rsp_data
);
   import byc_pkg::*;

   // nothing comes out in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // a stalled response holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // chroma only comes with valid luma
   a_chroma_in_area: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.chroma_valid |-> rsp_data.luma_valid)
      else $error("chroma outside the even picture area");

   // dropped pixels carry zero samples
   a_dropped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.luma_valid |->
         rsp_data.luma == 8'd0 && !rsp_data.chroma_valid)
      else $error("dropped pixel carries samples");

   // studio-range luma
   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.luma_valid |->
         rsp_data.luma >= 8'd16 && rsp_data.luma <= 8'd235)
      else $error("luma out of studio range");

endmodule

bind bgra_to_yuv420_converter byc_checker u_byc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- test/yuv420_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_checker
// Watches the pixel, result and register ports of the converter. It keeps
// its own copy of the frame size, counters and line sums, works out the
// luma and chroma that each accepted pixel should give, and compares every
// accepted result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module yuv420_checker #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  byc_pkg::req_payload_type           req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  byc_pkg::rsp_payload_type           rsp_data,
   input  logic                               csr_wr_en,
   input  logic [byc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [byc_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   output int                                 failures,
   output int                                 outstanding
);

   import byc_pkg::*;

   logic [CSR_DATA_W-1:0] line_width;
   logic [CSR_DATA_W-1:0] frame_height;
   logic [11:0]           col_pos;
   logic [11:0]           row_pos;
   pair_sum_type          first_of_pair;
   pair_sum_type          even_row_sums [MAX_WIDTH/2];
   rsp_payload_type       expected_samples [$];

   function automatic int clamp_size(logic [CSR_DATA_W-1:0] value, int limit);
      if (value < 2) return 2;
      if (value > limit) return limit;
      return int'(value);
   endfunction

   // Predict the result of one pixel and advance the raster position.
   function automatic rsp_payload_type convert_pixel(req_payload_type px);
      rsp_payload_type res;
      pair_sum_type    stored;
      int              len, hgt, sum_b, sum_g, sum_r, avg_b, avg_g, avg_r, u, v;
      logic [10:0]     slot;
      logic            line_last, frame_last;
      len        = clamp_size(line_width, MAX_WIDTH);
      hgt        = clamp_size(frame_height, MAX_HEIGHT);
      line_last  = col_pos >= len - 1;
      frame_last = line_last && (row_pos >= hgt - 1);
      slot       = col_pos[11:1];
      res        = '0;
      res.frame_end = frame_last;
      if (col_pos < (len & ~1) && row_pos < (hgt & ~1)) begin
         res.luma_valid = 1'b1;
         res.luma = 8'(((66 * px.red + 129 * px.green + 25 * px.blue + 128) >> 8) + 16);
         if (!col_pos[0]) begin
            first_of_pair = '{red: 9'(px.red), green: 9'(px.green), blue: 9'(px.blue)};
         end else begin
            sum_b = int'(first_of_pair.blue) + int'(px.blue);
            sum_g = int'(first_of_pair.green) + int'(px.green);
            sum_r = int'(first_of_pair.red) + int'(px.red);
            if (!row_pos[0]) begin
               even_row_sums[slot] = '{red: 9'(sum_r), green: 9'(sum_g), blue: 9'(sum_b)};
            end else begin
               stored = even_row_sums[slot];
               avg_b  = (sum_b + int'(stored.blue)) / 4;
               avg_g  = (sum_g + int'(stored.green)) / 4;
               avg_r  = (sum_r + int'(stored.red)) / 4;
               // the 128 offset is folded in before the shift, so both stay positive
               u = 112 * avg_b - 38 * avg_r - 74 * avg_g + 128 + 32768;
               v = 112 * avg_r - 94 * avg_g - 18 * avg_b + 128 + 32768;
               res.chroma_valid = 1'b1;
               res.cb = 8'(u >> 8);
               res.cr = 8'(v >> 8);
            end
         end
      end
      if (line_last) begin
         col_pos = '0;
         row_pos = frame_last ? '0 : row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
      return res;
   endfunction

   function automatic void check_field(string field, logic [7:0] wanted, logic [7:0] seen);
      if (seen !== wanted) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, wanted, seen);
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type wanted;
      if (reset) begin
         line_width    = LINE_WIDTH_RESET;
         frame_height  = FRAME_HEIGHT_RESET;
         col_pos       = '0;
         row_pos       = '0;
         first_of_pair = '0;
         expected_samples.delete();
      end else begin
         // a pixel taken at this edge still sees the old size
         if (req_valid && !req_stall)
            expected_samples.push_back(convert_pixel(req_data));
         if (csr_wr_en) begin
            case (csr_index)
               REG_LINE_WIDTH:   line_width   = csr_wr_data;
               REG_FRAME_HEIGHT: frame_height = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               failures++;
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            end else begin
               wanted = expected_samples.pop_front();
               check_field("luma", wanted.luma, rsp_data.luma);
               check_field("luma_valid", 8'(wanted.luma_valid), 8'(rsp_data.luma_valid));
               check_field("chroma_valid", 8'(wanted.chroma_valid),
                           8'(rsp_data.chroma_valid));
               check_field("cb", wanted.cb, rsp_data.cb);
               check_field("cr", wanted.cr, rsp_data.cr);
               check_field("frame_end", 8'(wanted.frame_end), 8'(rsp_data.frame_end));
            end
         end
      end
      outstanding = expected_samples.size();
   end

endmodule

// ----- test/tb_bgra_to_yuv420_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bgra_to_yuv420_converter
// Drives pixel streams of many frame sizes into the converter, stalls its
// output at random and lets yuv420_checker predict and compare every result.
// ----------------------------------------------------------------------------

module tb_bgra_to_yuv420_converter;

   import byc_pkg::*;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int RANDOM_PIXELS = 1200;
   localparam int WIDE_PIXELS   = 400;
   localparam int DRAIN_CYCLES  = 8;        // pipeline is 3 deep, leave some slack
   localparam int HOLD_OFF      = 300;
   localparam int CYCLE_LIMIT   = 1000000;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_payload_type        req_data    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = REG_LINE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   int failures;
   int outstanding;
   int cycle_count;
   int pixels_sent;
   int size_settings;
   bit calm;                 // no idling on either side while set
   bit hold_off_pending;     // ask the receiver for one long hold-off

   bgra_to_yuv420_converter #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   yuv420_checker #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up on a hung run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("FAIL");
      $finish;
   end

   // Receiver: random stall bursts, quiet stretches, and one long hold-off on
   // request so that the pipeline backs up into the pixel port.
   initial begin : receiver
      int cycles;
      @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            for (cycles = 0; cycles < HOLD_OFF; cycles++) @(posedge clock);
         end else if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // Mostly random bytes, with a bias towards the channel extremes.
   function automatic req_payload_type random_pixel();
      req_payload_type px;
      px = req_payload_type'(24'($urandom));
      if ($urandom_range(0, 7) == 0) px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 7) == 0) px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 7) == 0) px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return px;
   endfunction

   // Offer one pixel and hold it until taken. Stall is sampled on the falling
   // edge, where it has long settled; the request is taken at the next rising
   // edge. A random gap may follow.
   task automatic send_pixel(input req_payload_type px);
      bit taken;
      req_valid <= 1'b1;
      req_data  <= px;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      pixels_sent++;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every result is back and the pipe is empty.
   // The count is read on the falling edge, after the checker has updated it.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both size registers on back-to-back edges.
   task automatic set_frame_size(input logic [CSR_DATA_W-1:0] width,
                                 input logic [CSR_DATA_W-1:0] height);
      csr_wr_en   <= 1'b1;
      csr_index   <= REG_LINE_WIDTH;
      csr_wr_data <= width;
      @(posedge clock);
      csr_index   <= REG_FRAME_HEIGHT;
      csr_wr_data <= height;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      size_settings++;
   endtask

   initial begin : stimulus
      int width, height, len, hgt, random_count;
      pixels_sent   = 0;
      size_settings = 0;
      random_count  = 0;
      calm          = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset size (640 wide): start row 0 with black, white and pure blue.
      send_pixel('{blue: 8'd0,   green: 8'd0,   red: 8'd0});
      send_pixel('{blue: 8'd255, green: 8'd255, red: 8'd255});
      send_pixel('{blue: 8'd255, green: 8'd0,   red: 8'd0});
      send_pixel('{blue: 8'd255, green: 8'd0,   red: 8'd0});
      // Shrink the line mid-frame: the next pixel is past the new end and
      // closes row 0 without a valid luma.
      drain();
      set_frame_size(13'd4, 13'd2);
      send_pixel('{blue: 8'd0, green: 8'd255, red: 8'd0});
      // Row 1 completes both blocks: a grey average and full blue chroma.
      send_pixel('{blue: 8'd255, green: 8'd255, red: 8'd255});
      send_pixel('{blue: 8'd0,   green: 8'd0,   red: 8'd0});
      send_pixel('{blue: 8'd255, green: 8'd0,   red: 8'd0});
      send_pixel('{blue: 8'd255, green: 8'd0,   red: 8'd0});

      // Odd width and an oversized height: the last column carries nothing.
      drain();
      set_frame_size(13'd3, 13'd6000);
      send_pixel('{blue: 8'd0, green: 8'd0, red: 8'd255});
      send_pixel('{blue: 8'd0, green: 8'd0, red: 8'd255});
      send_pixel(random_pixel());
      send_pixel('{blue: 8'd0, green: 8'd0, red: 8'd255});
      send_pixel('{blue: 8'd0, green: 8'd0, red: 8'd255});
      repeat (4) send_pixel(random_pixel());
      // Cut the frame short at row 3 with a height below the minimum.
      drain();
      set_frame_size(13'd3, 13'd0);
      repeat (3) send_pixel(random_pixel());

      // A long stretch of row 0 at the clamped widest size, with the output
      // held off meanwhile; then a two-wide size closes row 0 at the next
      // pixel and a short row 1 closes the frame.
      drain();
      set_frame_size(13'd8191, 13'd4096);
      hold_off_pending = 1'b1;
      repeat (WIDE_PIXELS) send_pixel(random_pixel());
      drain();
      set_frame_size(13'd2, 13'd2);
      repeat (3) send_pixel(random_pixel());

      // Random sizes, one or two whole frames each; quiet towards the end.
      while (random_count < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0:       width = $urandom_range(0, 1);
            9:       width = $urandom_range(17, 40);
            default: width = $urandom_range(2, 16);
         endcase
         case ($urandom_range(0, 9))
            0:       height = $urandom_range(0, 1);
            9:       height = $urandom_range(7, 12);
            default: height = $urandom_range(2, 6);
         endcase
         len = (width < 2) ? 2 : width;
         hgt = (height < 2) ? 2 : height;
         drain();
         set_frame_size(CSR_DATA_W'(width), CSR_DATA_W'(height));
         calm = (random_count > RANDOM_PIXELS - 250) || ($urandom_range(0, 5) == 0);
         repeat ($urandom_range(1, 2)) begin
            repeat (len * hgt) begin
               send_pixel(random_pixel());
               random_count++;
            end
         end
      end

      calm = 1'b1;
      drain();
      $display("Converted %0d pixels over %0d frame size settings: odd, clamped and",
               pixels_sent, size_settings);
      $display("mid-frame sizes, a %0d-pixel run at the widest size and a long output hold-off",
               WIDE_PIXELS);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", failures);
         $display("FAIL");
      end
      $finish;
   end

endmodule
